// ===== sv/bfba_pkg.sv =====
// Package: widths, field types and float constants for the bf16 bias adder.
package bfba_pkg;
  localparam int ProjWidth = 16;
  localparam int BiasWidth = 32;
  localparam int SumWidth  = 16;
  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;

  typedef struct packed {
    logic [ProjWidth-1:0] proj_value;
    logic [BiasWidth-1:0] bias_value;
  } in_item_t;

  typedef struct packed {
    logic [SumWidth-1:0] sum_value;
  } out_item_t;

  // aligned operand pair after the swap/shift stage
  typedef struct packed {
    logic        special;
    logic [31:0] special_word;
    logic        sign_big;
    logic        sub;
    logic [7:0]  exp_big;
    logic [26:0] man_big;
    logic [26:0] man_small;
  } align_t;
endpackage

// ===== sv/bfba_if.sv =====
// Valid/ready stream interface carrying a payload of type T.
interface bfba_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bf16_plus_fp32_bias_add.sv =====
// Top level: bf16 plus fp32 bias add with bf16 truncated result.
// Usage:
//   in  channel: proj_value (bf16 bits) and bias_value (fp32 bits).
//   out channel: sum_value, upper 16 bits of the fp32 sum rounded to
//   nearest even (subnormals kept, NaN/inf per IEEE).
// Throughput: one transfer per cycle while the receiver keeps out_ready high.
// Path: input register, then the add/normalize path into the result register.
// Rate is set by the single add/normalize path between the two registers.
// Reset clears both valid flags; no results are pending afterward.
// When the receiver stalls, the result register holds and the input
// register holds behind it; in_ready drops only when both are full.
module bf16_plus_fp32_bias_add
  import bfba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bfba_if.sink   in_ch,
  bfba_if.source out_ch
);
  logic        s1_valid, s2_valid;
  in_item_t    s1_data;
  logic [15:0] s2_sum;
  logic        s2_load, s1_load;
  align_t      al;
  logic [31:0] sum;

  assign s2_load = s1_valid && (!s2_valid || out_ch.ready);
  assign s1_load = !s1_valid || s2_load;
  assign in_ch.ready = s1_load;

  bfba_align u_align (
    .a({s1_data.proj_value, 16'd0}),
    .b(s1_data.bias_value),
    .al(al)
  );
  bfba_norm u_norm (.al(al), .sum(sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= in_ch.valid;
      if (s2_load) s2_valid <= 1'b1;
      else if (out_ch.ready) s2_valid <= 1'b0;
    end
    if (s1_load && in_ch.valid) s1_data <= in_ch.data;
    if (s2_load) s2_sum <= sum[31:16];
  end

  assign out_ch.valid = s2_valid;
  assign out_ch.data.sum_value = s2_sum;
endmodule

// ===== sv/bfba_align.sv =====
// Operand unpack, special-case detection, swap and alignment shift.
module bfba_align
  import bfba_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output align_t      al
);
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [7:0]  ea, eb, ebig, esml, diff;
  logic [23:0] ma, mb;
  logic [26:0] mbig, msml, shifted;
  logic        sticky;
  logic [31:0] big, sml;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = a[30:0] == 31'h7F80_0000;
    b_inf = b[30:0] == 31'h7F80_0000;
    al.special = 1'b1;
    if (a_nan) al.special_word = a | 32'h0040_0000;
    else if (b_nan) al.special_word = b | 32'h0040_0000;
    else if (a_inf && b_inf && (a[31] != b[31])) al.special_word = DefaultNan;
    else if (a_inf) al.special_word = a;
    else if (b_inf) al.special_word = b;
    else begin
      al.special = 1'b0;
      al.special_word = 32'd0;
    end
    swap = b[30:0] > a[30:0];
    big  = swap ? b : a;
    sml  = swap ? a : b;
    ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    ma   = {big[30:23] != 8'd0, big[22:0]};
    mb   = {sml[30:23] != 8'd0, sml[22:0]};
    ea   = ebig;
    eb   = esml;
    diff = ea - eb;
    mbig = {ma, 3'b000};
    msml = {mb, 3'b000};
    if (diff >= 8'd27) begin
      shifted = 27'd0;
      sticky  = msml != 27'd0;
    end else begin
      shifted = msml >> diff;
      sticky  = (msml & ~(27'h7FF_FFFF << diff)) != 27'd0;
    end
    al.sign_big  = big[31];
    al.sub       = big[31] ^ sml[31];
    al.exp_big   = ea;
    al.man_big   = mbig;
    al.man_small = {shifted[26:1], shifted[0] | sticky};
  end
endmodule

// ===== sv/bfba_norm.sv =====
// Add/subtract, normalize, round to nearest even and pack.
module bfba_norm
  import bfba_pkg::*;
(
  input  align_t      al,
  output logic [31:0] sum
);
  logic [27:0] s;
  logic [27:0] m;
  logic [9:0]  e;
  logic [4:0]  lz;
  logic [24:0] r;
  logic        g, st, rnd;
  logic        found;

  always_comb begin
    s = al.sub ? ({1'b0, al.man_big} - {1'b0, al.man_small})
               : ({1'b0, al.man_big} + {1'b0, al.man_small});
    e = {2'b00, al.exp_big};
    m = s;
    lz = 5'd0;
    found = 1'b0;
    if (s[27]) begin
      m = {1'b0, s[27:2], s[1] | s[0]};
      e = e + 10'd1;
    end else begin
      for (int i = 26; i >= 0; i--) begin
        if (!found && s[i]) begin
          found = 1'b1;
          lz = 5'(26 - i);
        end
      end
      if ({5'd0, lz} >= e) lz = 5'(e - 10'd1);
      m = s << lz;
      e = e - {5'd0, lz};
    end
    g   = m[2];
    st  = m[1] | m[0];
    rnd = g & (st | m[3]);
    r   = {1'b0, m[26:3]} + {24'd0, rnd};
    if (r[24]) begin
      r = r >> 1;
      e = e + 10'd1;
    end
    if (al.special) sum = al.special_word;
    else if (s == 28'd0) sum = {al.sign_big & ~al.sub, 31'd0};
    else if (e >= 10'd255) sum = {al.sign_big, 8'hFF, 23'd0};
    else if (!r[23]) sum = {al.sign_big, 8'd0, r[22:0]};
    else sum = {al.sign_big, e[7:0], r[22:0]};
  end
endmodule

// ===== sv/bfba_checker.sv =====
// Port-level checker for the bias adder, bound to the top level.
module bfba_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] sum_value
);
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum_value))
    else $error("stalled result changed");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after two cycles");
endmodule

bind bf16_plus_fp32_bias_add bfba_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .sum_value(out_ch.data.sum_value)
);
